@@ design/cap_pkg.sv @@
`default_nettype none

package cap_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 11;
  localparam int THR_W     = 4;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WALL_AT_LEAST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_BELOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 2'd2;

  localparam logic [THR_W-1:0] WALL_AT_LEAST_RST = 4'd5;
  localparam logic [THR_W-1:0] WALL_BELOW_RST    = 4'd1;
  localparam logic [ROW_W-1:0] ROW_WIDTH_RST     = ROW_W'(MAX_WIDTH);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic new_wall;
    logic run_last;
    logic frame_last;
  } result_t;

  // up to two results pushed per cycle, e0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    e0;
    result_t    e1;
  } push_t;

endpackage

`default_nettype wire

@@ design/cap_result_fifo.sv @@
`default_nettype none

module cap_result_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cap_pkg::push_t  push,
  input  wire logic            pop_ready,
  output logic                 pop_valid,
  output cap_pkg::result_t     pop_data,
  output logic [cap_pkg::FIFO_CW-1:0] count
);

  cap_pkg::result_t               mem_r [cap_pkg::FIFO_DEPTH];
  logic [cap_pkg::FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [cap_pkg::FIFO_CW-1:0]    count_r, count_nxt;
  logic                           pop;
  logic [cap_pkg::FIFO_AW-1:0]    wr_ptr_p1;

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = count_r;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r + cap_pkg::FIFO_CW'(push.n) - cap_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + cap_pkg::FIFO_AW'(push.n);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.e0;
    if (push.n == 2'd2) mem_r[wr_ptr_p1] <= push.e1;
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_pkg::FIFO_CW'(cap_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |->
      ({1'b0, count_r} + (cap_pkg::FIFO_CW+1)'(push.n)
        <= (cap_pkg::FIFO_CW+1)'(cap_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  a_ptrs_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[cap_pkg::FIFO_AW-1:0])
    else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

@@ design/cave_automaton_pass.sv @@
`default_nettype none

// one smoothing pass of a cave automaton over a one-bit wall map in raster order
// in_*  : one cell per transfer (in_mode 0 map cell, 1 flush cell of the closing wall row)
// out_* : results in raster order, one row behind the input; up to two per input
//         cell (the last column also emits the final cell of the row above)
// cfg_* : register writes (wall_at_least, wall_below, row_width), always ready;
//         write only while the block is idle
// throughput: one input cell per cycle while the queue has room, set by the single
//   read (front) / write back (stage two) of the two line stores (1024 x 1 each)
// results: each is formed in stage two from the registered cell and offered from
//   the result queue once written there; the first map row gives no results
// results go through an 8-entry queue; in_ready falls while the queue cannot
//   take two more results for each cell in flight, so a stalled receiver
//   holds the input side and nothing is lost
// reset: thresholds 5 and 1, row width 1024, column 0, start of frame; the
//   line stores are not cleared, each entry is written before its value is used
module cave_automaton_pass (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_mode,
  input  wire logic                          in_cell_wall,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_new_wall,
  output logic                               out_run_last,
  output logic                               out_frame_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cap_pkg::ROW_W-1:0]     cfg_data
);

  localparam int COL_W = cap_pkg::COL_W;

  // configuration
  logic [cap_pkg::THR_W-1:0] at_least_r, below_r;
  logic [cap_pkg::ROW_W-1:0] row_width_r;

  // front state
  logic [COL_W-1:0] col_r;
  logic [1:0]       rows_seen_r;

  // second stage
  logic             b_valid_r;
  logic [COL_W-1:0] x_b_r;
  logic             cur_b_r, last_b_r, emit_b_r, up_en_b_r, fe_b_r;
  logic             upper_rd_r, middle_rd_r;
  logic             fwd_r, fwd_up_r, fwd_mid_r;
  logic [8:0]       win_r;

  logic upper_mem  [cap_pkg::MAX_WIDTH];
  logic middle_mem [cap_pkg::MAX_WIDTH];

  logic [cap_pkg::ROW_W-1:0] w_clamp;
  logic [COL_W-1:0]          w_m1, x_a;
  logic                      last_a, flush_a, cur_a, accept;
  logic [cap_pkg::FIFO_CW:0] load;

  logic             upper_raw, middle_raw, up_bit, mid_bit;
  logic [8:0]       win_base, win1, win2;
  logic             r1, r2, emit1, emit2;
  cap_pkg::push_t   push;
  cap_pkg::result_t head;
  logic [cap_pkg::FIFO_CW-1:0] fifo_count;

  function automatic logic wall_rule(input logic [8:0] win,
                                     input logic [cap_pkg::THR_W-1:0] at_least,
                                     input logic [cap_pkg::THR_W-1:0] below);
    logic [cap_pkg::CNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < 9; i++) cnt = cnt + cap_pkg::CNT_W'(win[i]);
    return (cnt >= at_least) || (cnt < below);
  endfunction

  // ---------------- front: column tracking and store read
  always_comb begin
    if (row_width_r == '0) begin
      w_clamp = cap_pkg::ROW_W'(1);
    end else if (row_width_r > cap_pkg::ROW_W'(cap_pkg::MAX_WIDTH)) begin
      w_clamp = cap_pkg::ROW_W'(cap_pkg::MAX_WIDTH);
    end else begin
      w_clamp = row_width_r;
    end
  end

  assign w_m1    = COL_W'(w_clamp - cap_pkg::ROW_W'(1));
  assign x_a     = (col_r > w_m1) ? w_m1 : col_r;
  assign last_a  = (x_a == w_m1);
  assign flush_a = in_mode;
  assign cur_a   = in_mode | in_cell_wall;

  // room for the in-flight cell's results and this cell's
  assign load     = {1'b0, fifo_count} + (b_valid_r ? (cap_pkg::FIFO_CW+1)'(2) : '0);
  assign in_ready = (load <= (cap_pkg::FIFO_CW+1)'(cap_pkg::FIFO_DEPTH - 2));
  assign accept   = in_valid && in_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_least_r  <= cap_pkg::WALL_AT_LEAST_RST;
      below_r     <= cap_pkg::WALL_BELOW_RST;
      row_width_r <= cap_pkg::ROW_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cap_pkg::REG_WALL_AT_LEAST: at_least_r  <= cfg_data[cap_pkg::THR_W-1:0];
        cap_pkg::REG_WALL_BELOW:    below_r     <= cfg_data[cap_pkg::THR_W-1:0];
        cap_pkg::REG_ROW_WIDTH:     row_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      rows_seen_r <= '0;
      b_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      b_valid_r <= accept;
      if (accept) begin
        // same entry written by the cell now in stage two: read sees old data
        fwd_r <= b_valid_r && (x_b_r == x_a);
        if (last_a) begin
          col_r <= '0;
          if (flush_a) rows_seen_r <= '0;
          else if (rows_seen_r != 2'd2) rows_seen_r <= rows_seen_r + 1'b1;
        end else begin
          col_r <= x_a + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_b_r       <= x_a;
      cur_b_r     <= cur_a;
      last_b_r    <= last_a;
      emit_b_r    <= (rows_seen_r != 2'd0);
      up_en_b_r   <= (rows_seen_r == 2'd2);
      fe_b_r      <= last_a && flush_a;
      fwd_up_r    <= middle_raw;
      fwd_mid_r   <= cur_b_r;
      upper_rd_r  <= upper_mem[x_a];
      middle_rd_r <= middle_mem[x_a];
    end
    if (b_valid_r) begin
      upper_mem[x_b_r]  <= middle_raw;
      middle_mem[x_b_r] <= cur_b_r;
    end
  end

  // ---------------- stage two: window, rule, write back
  assign upper_raw  = fwd_r ? fwd_up_r  : upper_rd_r;
  assign middle_raw = fwd_r ? fwd_mid_r : middle_rd_r;
  assign up_bit     = up_en_b_r ? upper_raw  : 1'b1;
  assign mid_bit    = emit_b_r  ? middle_raw : 1'b1;

  // three columns of (upper, middle, current), newest in the top bits
  assign win_base = (x_b_r == '0) ? 9'h1FF : win_r;
  assign win1     = {cur_b_r, mid_bit, up_bit, win_base[8:3]};
  assign win2     = {3'b111, win1[8:3]};

  assign r1    = wall_rule(win1, at_least_r, below_r);
  assign r2    = wall_rule(win2, at_least_r, below_r);
  assign emit1 = b_valid_r && emit_b_r && (x_b_r != '0);
  assign emit2 = b_valid_r && emit_b_r && last_b_r;

  always_comb begin
    push = '0;
    if (emit1 && emit2) begin
      push.n  = 2'd2;
      push.e0 = '{new_wall: r1, run_last: 1'b0, frame_last: 1'b0};
      push.e1 = '{new_wall: r2, run_last: 1'b1, frame_last: fe_b_r};
    end else if (emit1) begin
      push.n  = 2'd1;
      push.e0 = '{new_wall: r1, run_last: 1'b1, frame_last: 1'b0};
    end else if (emit2) begin
      push.n  = 2'd1;
      push.e0 = '{new_wall: r2, run_last: 1'b1, frame_last: fe_b_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 9'h1FF;
    end else if (b_valid_r) begin
      win_r <= last_b_r ? win2 : win1;
    end
  end

  cap_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (head),
    .count     (fifo_count)
  );

  assign out_new_wall   = head.new_wall;
  assign out_run_last   = head.run_last;
  assign out_frame_last = head.frame_last;

  a_stage_two_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> $past(in_valid && in_ready))
    else $error("stage two busy without an input transfer");

  a_forward_needs_writer: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && fwd_r) |-> (x_b_r == $past(x_b_r, 1) && $past(b_valid_r, 1)))
    else $error("line store forwarding without a matching write");

  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last) |-> out_run_last)
    else $error("frame end not on the last result of a cell");

endmodule

`default_nettype wire
